### hdl/modular_arithmetic_unit_macros.svh
// assertion macros for the modular arithmetic unit
// used by the rtl files that assert, no other dependencies
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define MAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mau_pkg.sv
// types, constants and sequencer states of the modular arithmetic unit
// no dependencies
`default_nettype none
package mau_pkg;
  localparam int WORD_WIDTH = 64;
  localparam int OPW = WORD_WIDTH - 1;
  localparam int CNT_W = $clog2(OPW);

  typedef logic [OPW-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t operand_a;
    word_t operand_b;
  } in_word_t;

  typedef struct packed {
    word_t result;
    logic  defined;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_ADDSUB,
    S_MUL,
    S_CHK,
    S_GCD,
    S_DIVA,
    S_DIVB,
    S_DIVN,
    S_EUC,
    S_QRED,
    S_QMUL,
    S_APG,
    S_APRED,
    S_FMUL,
    S_FIN
  } state_t;
endpackage
`default_nettype wire

### hdl/mau_div.sv
// restoring divider, one quotient bit per cycle
// depends on mau_pkg
`default_nettype none
module mau_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mau_pkg::word_t dividend,
  input  mau_pkg::word_t divisor,
  output logic          done,
  output mau_pkg::word_t quo,
  output mau_pkg::word_t rem
);
  import mau_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  word_t            q, r, d;
  word_t            q_next, r_next;
  logic [OPW:0]     t, diff;
  logic             ge;

  always_comb begin
    t      = {r, q[OPW-1]};
    ge     = t >= {1'b0, d};
    diff   = t - {1'b0, d};
    r_next = ge ? diff[OPW-1:0] : t[OPW-1:0];
    q_next = {q[OPW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(OPW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quo = q;
  assign rem = r;
endmodule
`default_nettype wire

### hdl/mau_mul.sv
// modular multiplier, double then add per operand bit
// depends on mau_pkg; both operands must already be below the modulus
`default_nettype none
module mau_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mau_pkg::word_t x,
  input  mau_pkg::word_t y,
  input  mau_pkg::word_t m,
  output logic          done,
  output mau_pkg::word_t prod
);
  import mau_pkg::*;

  logic             busy, phase;
  logic [CNT_W-1:0] cnt;
  word_t            r, xr, yr, mr, addend;
  logic [OPW:0]     s, red;

  always_comb begin
    addend = phase ? (yr[OPW-1] ? xr : '0) : r;
    s      = {1'b0, r} + {1'b0, addend};
    red    = (s >= {1'b0, mr}) ? s - {1'b0, mr} : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(OPW - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r  <= '0;
      xr <= x;
      yr <= y;
      mr <= m;
    end else if (busy) begin
      r <= red[OPW-1:0];
      if (phase) begin
        yr <= {yr[OPW-2:0], 1'b0};
      end
    end
  end

  assign prod = r;
endmodule
`default_nettype wire

### hdl/modular_arithmetic_unit.sv
// modular arithmetic unit: add, subtract, multiply and divide under a modulus
// depends on mau_pkg, mau_div, mau_mul and modular_arithmetic_unit_macros.svh
//
// channel   direction  handshake             word
// in        in         in_valid / in_stall   op, operand_a, operand_b
// out       out        out_valid / out_stall result, defined
// cfg       in         cfg_valid / cfg_ready modulus
//
// one word at a time; each division runs in the shared divider, each modular
// product in the multiplier
// divide: gcd divisions, three scale divisions, euclid steps of a division,
// a reduction and a product, then a check, a reduction and the final product
// reset clears the sequencer and sets the modulus to one
// a stalled output holds while the next word is still being worked
`default_nettype none
`include "modular_arithmetic_unit_macros.svh"
module modular_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mau_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mau_pkg::out_word_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mau_pkg::word_t     cfg_data
);
  import mau_pkg::*;

  state_t       state, state_next;
  logic         pend, ok_r, g_phase;
  op_t          op_r;
  word_t        modulus;
  word_t        a_r, b_r, n_r, gx, gy, r0, r1, s0, s1, qq, res_r;
  logic         div_go, mul_go, div_done, mul_done;
  word_t        div_x, div_y, div_quo, div_rem, mul_x, mul_y, mul_prod;
  logic [OPW:0] add_s;
  word_t        add_res, sub_res, st;

  mau_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_x), .divisor(div_y),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  mau_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .x(mul_x), .y(mul_y), .m(n_r),
    .done(mul_done), .prod(mul_prod)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    add_s   = {1'b0, a_r} + {1'b0, b_r};
    add_res = (add_s >= {1'b0, n_r}) ? (add_s[OPW-1:0] - n_r) : add_s[OPW-1:0];
    sub_res = (a_r >= b_r) ? (a_r - b_r) : (a_r + (n_r - b_r));
    st      = (s0 >= mul_prod) ? (s0 - mul_prod) : (s0 + (n_r - mul_prod));
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    mul_go     = 1'b0;
    div_x      = a_r;
    div_y      = n_r;
    mul_x      = a_r;
    mul_y      = b_r;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (modulus == '0) state_next = S_FIN;
          else if (in_data.op == OP_DIV) state_next = S_CHK;
          else state_next = S_RED_A;
        end
      end
      S_RED_A: begin
        div_go = !pend;
        if (div_done) state_next = S_RED_B;
      end
      S_RED_B: begin
        div_x  = b_r;
        div_go = !pend;
        if (div_done) state_next = (op_r == OP_MUL) ? S_MUL : S_ADDSUB;
      end
      S_ADDSUB: state_next = S_FIN;
      S_MUL: begin
        mul_go = !pend;
        if (mul_done) state_next = S_FIN;
      end
      S_CHK: state_next = (b_r == '0) ? S_FIN : S_GCD;
      S_GCD: begin
        div_x = gx;
        div_y = gy;
        if (!pend && gy == '0) begin
          if (g_phase) state_next = S_DIVA;
        end else begin
          div_go = !pend;
        end
      end
      S_DIVA: begin
        div_y  = gx;
        div_go = !pend;
        if (div_done) state_next = S_DIVB;
      end
      S_DIVB: begin
        div_x  = b_r;
        div_y  = gx;
        div_go = !pend;
        if (div_done) state_next = S_DIVN;
      end
      S_DIVN: begin
        div_x  = n_r;
        div_y  = gx;
        div_go = !pend;
        if (div_done) state_next = S_EUC;
      end
      S_EUC: begin
        div_x = r0;
        div_y = r1;
        if (!pend && r1 == '0) begin
          state_next = S_APG;
        end else begin
          div_go = !pend;
          if (div_done) state_next = S_QRED;
        end
      end
      S_QRED: begin
        div_x  = qq;
        div_go = !pend;
        if (div_done) state_next = S_QMUL;
      end
      S_QMUL: begin
        mul_x  = qq;
        mul_y  = s1;
        mul_go = !pend;
        if (mul_done) state_next = S_EUC;
      end
      S_APG: begin
        div_y  = r0;
        div_go = !pend;
        if (div_done) state_next = (div_rem != '0) ? S_FIN : S_APRED;
      end
      S_APRED: begin
        div_x  = qq;
        div_go = !pend;
        if (div_done) state_next = S_FMUL;
      end
      S_FMUL: begin
        mul_x  = s0;
        mul_y  = qq;
        mul_go = !pend;
        if (mul_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      modulus   <= word_t'(1);
    end else begin
      state <= state_next;
      if (div_go || mul_go) pend <= 1'b1;
      else if (div_done || mul_done) pend <= 1'b0;
      if (state == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid) modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r    <= in_data.op;
          a_r     <= in_data.operand_a;
          b_r     <= in_data.operand_b;
          gx      <= in_data.operand_a;
          gy      <= in_data.operand_b;
          n_r     <= modulus;
          ok_r    <= (modulus != '0);
          res_r   <= '0;
          g_phase <= 1'b0;
        end
      end
      S_RED_A:  if (div_done) a_r <= div_rem;
      S_RED_B:  if (div_done) b_r <= div_rem;
      S_ADDSUB: res_r <= (op_r == OP_ADD) ? add_res : sub_res;
      S_MUL:    if (mul_done) res_r <= mul_prod;
      S_CHK:    if (b_r == '0) ok_r <= 1'b0;
      S_GCD: begin
        if (!pend && gy == '0 && !g_phase) begin
          g_phase <= 1'b1;
          gy      <= n_r;
        end else if (div_done) begin
          gx <= gy;
          gy <= div_rem;
        end
      end
      S_DIVA: if (div_done) a_r <= div_quo;
      S_DIVB: if (div_done) b_r <= div_quo;
      S_DIVN: begin
        if (div_done) begin
          n_r <= div_quo;
          r0  <= b_r;
          r1  <= div_quo;
          s0  <= (div_quo == word_t'(1)) ? '0 : word_t'(1);
          s1  <= '0;
        end
      end
      S_EUC: begin
        if (div_done) begin
          qq <= div_quo;
          r0 <= r1;
          r1 <= div_rem;
        end
      end
      S_QRED: if (div_done) qq <= div_rem;
      S_QMUL: begin
        if (mul_done) begin
          s0 <= s1;
          s1 <= st;
        end
      end
      S_APG: begin
        if (div_done) begin
          if (div_rem != '0) ok_r <= 1'b0;
          qq <= div_quo;
        end
      end
      S_APRED: if (div_done) qq <= div_rem;
      S_FMUL:  if (mul_done) res_r <= mul_prod;
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_data.result  <= ok_r ? res_r : '0;
          out_data.defined <= ok_r;
        end
      end
      default: ;
    endcase
  end

  `MAU_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall,
                   state != S_IDLE, "word accepted but sequencer idle")
  `MAU_ASSERT_IMPL(a_undef_zero, clk, rst, out_valid && !out_data.defined,
                   out_data.result == '0, "undefined word carries a result")
  `MAU_ASSERT_IMPL(a_done_pending, clk, rst, div_done || mul_done,
                   pend, "unit finished without a request")
  `MAU_ASSERT_IMPL(a_result_reduced, clk, rst, out_valid && out_data.defined,
                   out_data.result < modulus, "result not reduced")
endmodule
`default_nettype wire

### tb/mau_checker.sv
// checker for the modular arithmetic unit: follows the modulus writes, predicts every
// accepted word and compares the output words in order; depends on mau_pkg only
module mau_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mau_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mau_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  mau_pkg::word_t     cfg_data,
  output int                 failures,
  output int                 pending
);
  import mau_pkg::*;

  typedef logic [63:0] u64_t;

  u64_t      modulus_q;
  out_word_t expected_q[$];

  function automatic u64_t mod_mul(u64_t x, u64_t y, u64_t m);
    logic [127:0] p;
    p = (x % m) * (y % m);
    return u64_t'(p % m);
  endfunction

  function automatic u64_t mod_sub(u64_t x, u64_t y, u64_t m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  function automatic u64_t gcd_of(u64_t x, u64_t y);
    u64_t t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_word_t predict_word(in_word_t w, u64_t n);
    out_word_t o;
    u64_t a, b, r, ap, bp, np, r0, r1, s0, s1, q, rt, st;
    a = u64_t'(w.operand_a);
    b = u64_t'(w.operand_b);
    o.result  = '0;
    o.defined = 1'b1;
    if (n == 0) begin
      o.defined = 1'b0;
    end else begin
      case (w.op)
        OP_ADD: begin
          o.result = word_t'(((a % n) + (b % n)) % n);
        end
        OP_SUB: begin
          o.result = word_t'(mod_sub(a % n, b % n, n));
        end
        OP_MUL: begin
          o.result = word_t'(mod_mul(a, b, n));
        end
        default: begin
          if (b == 0) begin
            o.defined = 1'b0;
          end else begin
            r  = gcd_of(gcd_of(a, b), n);
            ap = a / r;
            bp = b / r;
            np = n / r;
            r0 = bp;
            r1 = np;
            s0 = 1 % np;
            s1 = 0;
            while (r1 != 0) begin
              q  = r0 / r1;
              rt = r0 - q * r1;
              st = mod_sub(s0, mod_mul(q, s1, np), np);
              r0 = r1;
              r1 = rt;
              s0 = s1;
              s1 = st;
            end
            if (ap % r0 != 0) o.defined = 1'b0;
            else o.result = word_t'(mod_mul(s0, ap / r0, np));
          end
        end
      endcase
    end
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      modulus_q <= 64'd1;
      failures  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) modulus_q <= u64_t'(cfg_data);
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(), predict_word(in_data, modulus_q));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word result=%0d defined=%0b", $time,
                   out_data.result, out_data.defined);
          failures <= failures + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.result !== out_data.result || e.defined !== out_data.defined) begin
            $display("%0t: expected result=%0d defined=%0b, got result=%0d defined=%0b",
                     $time, e.result, e.defined, out_data.result, out_data.defined);
            failures <= failures + 1;
          end
        end
      end
    end
  end
endmodule

### tb/modular_arithmetic_unit_test.sv
// top of the modular arithmetic unit testbench: clock, reset, word stimulus, output stall
// and verdict; depends on mau_pkg, modular_arithmetic_unit and mau_checker
module modular_arithmetic_unit_test;
  import mau_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [62:0] WORD_MAX = {63{1'b1}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  word_t     cfg_data = '0;
  int        failures, pending;
  bit        sender_paced;
  int        idle_cycles = 0;
  int        words_read;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  modular_arithmetic_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mau_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  function automatic word_t pick_operand(word_t n);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      2, 3: return rand_word();
      4: return n - 1;
      5: return n;
      default: return word_t'(rand_word() % ({1'b0, n} * 2));
    endcase
  endfunction

  task automatic send_word(op_t op, word_t a, word_t b);
    int gap;
    gap = sender_paced ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_modulus(word_t n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(word_t n, int count);
    drain();
    write_modulus(n);
    sender_paced = $urandom_range(0, 3) != 0;
    repeat (count) begin
      send_word(op_t'($urandom_range(0, 3)), pick_operand(n), pick_operand(n));
    end
  endtask

  // output side: random stall per word, one long hold to back the block up
  initial begin
    int gap;
    words_read = 0;
    @(negedge rst);
    forever begin
      gap = (words_read % 4 == 3) ? 0 : $urandom_range(0, 5);
      if (words_read == 300) gap = 600;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      words_read++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sender_paced = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus of one
    send_word(OP_ADD, WORD_MAX, WORD_MAX);
    send_word(OP_MUL, WORD_MAX, 63'd5);
    send_word(OP_DIV, 63'd7, 63'd3);
    send_word(OP_DIV, 63'd7, 63'd0);

    drain();
    write_modulus(63'd12);
    send_word(OP_ADD, 63'd11, 63'd11);
    send_word(OP_SUB, 63'd0, 63'd1);
    send_word(OP_SUB, 63'd5, 63'd29);
    send_word(OP_MUL, WORD_MAX, WORD_MAX);
    send_word(OP_DIV, 63'd5, 63'd0);
    send_word(OP_DIV, 63'd1, 63'd4);
    send_word(OP_DIV, 63'd8, 63'd4);
    send_word(OP_DIV, 63'd6, 63'd18);
    send_word(OP_DIV, 63'd0, 63'd7);
    send_word(OP_DIV, WORD_MAX, 63'd5);

    drain();
    write_modulus(WORD_MAX);
    send_word(OP_ADD, WORD_MAX, WORD_MAX);
    send_word(OP_SUB, 63'd0, WORD_MAX - 1);
    send_word(OP_MUL, WORD_MAX - 1, WORD_MAX - 1);
    send_word(OP_DIV, 63'd1, WORD_MAX - 1);
    send_word(OP_DIV, WORD_MAX - 2, 63'd3);

    run_phase(63'd2, 60);
    run_phase(63'd97, 180);
    run_phase(63'd360360, 200);
    run_phase(63'd65521, 180);
    run_phase(word_t'($urandom_range(1, 65535)), 200);
    run_phase(word_t'($urandom), 170);
    run_phase(63'd1, 40);
    run_phase({1'b1, 62'd0}, 40);
    run_phase(WORD_MAX, 40);
    run_phase(rand_word() | 63'd1, 40);
    run_phase(word_t'($urandom_range(2, 4096)), 150);

    drain();
    repeat (300) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

### modular_arithmetic_unit.f
+incdir+hdl
hdl/mau_pkg.sv
hdl/mau_div.sv
hdl/mau_mul.sv
hdl/modular_arithmetic_unit.sv
tb/mau_checker.sv
tb/modular_arithmetic_unit_test.sv
